[src/tccb_pkg.sv]
package tccb_pkg;

  // Default store geometry
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // Port field widths
  localparam int CELL_W = 16;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  // Character codes with special meaning
  localparam logic [CELL_W-1:0] CH_BACKSPACE = 16'd8;
  localparam logic [CELL_W-1:0] CH_NEWLINE   = 16'd10;
  localparam logic [CELL_W-1:0] CH_RETURN    = 16'd13;
  localparam logic [CELL_W-1:0] CH_SPACE     = 16'd32;
  localparam logic [CELL_W-1:0] CH_NUL       = 16'd0;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [CELL_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_item_t;

endpackage

[src/tccb_cell_mem.sv]
module tccb_cell_mem
  import tccb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF,
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLS + 1),
  localparam int AW = RW + CW
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  // Row stride is a power of two: address is {row, col}
  localparam int DEPTH = ROWS * (2 ** CW);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/tccb_ctrl.sv]
module tccb_ctrl
  import tccb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF,
  localparam int RW = $clog2(ROWS),
  localparam int CW = $clog2(COLS + 1),
  localparam int AW = RW + CW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  input  logic              res_free,
  output logic              res_valid,
  output out_item_t         res_item,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_PUT2   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     sr_r, sr_nxt;
  logic [CW-1:0]     sc_r, sc_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              rd_done_r, rd_done_nxt;
  logic [CELL_W-1:0] val_r, val_nxt;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    rd_done_nxt   = rd_done_r;
    val_nxt       = val_r;
    mem_we        = 1'b0;
    mem_waddr     = {row_r, col_r};
    mem_wdata     = CH_NUL;
    mem_raddr     = {sr_r, sc_r};
    unique case (state_r)
      S_CLEAR: begin
        // zero one cell per cycle, terminator slot included
        mem_we    = 1'b1;
        mem_waddr = {sr_r, sc_r};
        if (sc_r == CW'(COLS)) begin
          sc_nxt = '0;
          if (sr_r == RW'(ROWS - 1)) begin
            sr_nxt    = '0;
            state_nxt = S_IDLE;
          end else begin
            sr_nxt = sr_r + 1'b1;
          end
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          val_nxt = CH_NUL;
          if (in_item.cmd == CMD_READ) begin
            if (32'(in_item.read_row) < ROWS && 32'(in_item.read_col) <= COLS) begin
              mem_raddr = {RW'(in_item.read_row), CW'(in_item.read_col)};
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_EMIT;
            end
          end else begin
            unique case (in_item.char_code) inside
              CH_BACKSPACE: begin
                if (col_r != '0) begin
                  col_nxt   = col_r - 1'b1;
                  mem_we    = 1'b1;
                  mem_waddr = {row_r, col_r - 1'b1};
                  mem_wdata = CH_SPACE;
                end
                state_nxt = S_EMIT;
              end
              CH_NEWLINE, CH_RETURN: begin
                col_nxt = '0;
                if (32'(row_r) + 1 >= ROWS) begin
                  sr_nxt      = RW'(1);
                  sc_nxt      = '0;
                  pend_nxt    = 1'b0;
                  rd_done_nxt = 1'b0;
                  state_nxt   = S_SCROLL;
                end else begin
                  row_nxt   = row_r + 1'b1;
                  state_nxt = S_EMIT;
                end
              end
              default: begin
                if (32'(col_r) < COLS) begin
                  mem_we    = 1'b1;
                  mem_waddr = {row_r, col_r};
                  mem_wdata = in_item.char_code;
                  col_nxt   = col_r + 1'b1;
                  state_nxt = S_PUT2;
                end else begin
                  state_nxt = S_EMIT;
                end
              end
            endcase
          end
        end
      end
      S_RDWAIT: begin
        val_nxt   = mem_rdata;
        state_nxt = S_EMIT;
      end
      S_PUT2: begin
        // terminate after the stored character
        mem_we    = 1'b1;
        mem_waddr = {row_r, col_r};
        mem_wdata = CH_NUL;
        state_nxt = S_EMIT;
      end
      S_SCROLL: begin
        // write the cell read last cycle one row up, read the next one
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = mem_rdata;
        end
        if (!rd_done_r) begin
          mem_raddr     = {sr_r, sc_r};
          pend_nxt      = 1'b1;
          pend_addr_nxt = {sr_r - 1'b1, sc_r};
          if (sc_r == CW'(COLS - 1)) begin
            sc_nxt = '0;
            if (sr_r == RW'(ROWS - 1)) begin
              rd_done_nxt = 1'b1;
            end else begin
              sr_nxt = sr_r + 1'b1;
            end
          end else begin
            sc_nxt = sc_r + 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            sc_nxt    = '0;
            state_nxt = S_FILL;
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = {RW'(ROWS - 1), sc_r};
        mem_wdata = CH_SPACE;
        if (sc_r == CW'(COLS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      row_r     <= '0;
      col_r     <= '0;
      sr_r      <= '0;
      sc_r      <= '0;
      pend_r    <= 1'b0;
      rd_done_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      sr_r      <= sr_nxt;
      sc_r      <= sc_nxt;
      pend_r    <= pend_nxt;
      rd_done_r <= rd_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    val_r       <= val_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res_item  = '{cell_value: val_r,
                       cursor_row: ROW_W'(row_r),
                       cursor_col: COL_W'(col_r)};

  a_scroll_writes_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL && pend_r) |-> mem_we)
    else $error("pending scroll cell not written");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) <= COLS))
    else $error("cursor column beyond terminator slot");

  a_fill_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (row_r == RW'(ROWS - 1) && col_r == '0))
    else $error("fill with cursor off the last row start");

  a_clear_leaves_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && state_nxt == S_IDLE) |=> (row_r == '0 && col_r == '0))
    else $error("cursor not home after clear pass");

endmodule

[src/text_console_cell_buffer.sv]
// Text console cell buffer: a ROWS x (COLS+1) store of 16-bit character
// cells (column COLS is the terminator slot) plus a cursor. A put edits the
// store at the cursor (backspace, newline/return, or a printable code that
// is stored and followed by a zero); a read returns one cell, zero when out
// of range. Every transfer in gives exactly one result with the cursor after
// the step. After reset the block clears the store one cell per cycle, all
// ROWS*(COLS+1) cells, and holds in_stall high meanwhile.
// Sequencing, set by the single-port-write cell memory and its sequencer: a
// read issues the address, takes the cell in RDWAIT, then emits; an in-range
// printable put stores the code, then the zero after it in PUT2; a backspace
// or a plain newline emits at once; a newline on the last row copies cells
// one per cycle through the memory (SCROLL), then fills the last row with
// spaces (FILL). One item is worked on at a time; a finished result sits in
// the output register so the next item can be taken while it waits.
module text_console_cell_buffer
  import tccb_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS + 1);
  localparam int AW = RW + CW;

  logic              res_free;
  logic              res_valid;
  out_item_t         res_item;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              out_valid_r;
  out_item_t         out_data_r;

  // Sequencer: cursor, command decode, clear, scroll and fill sweeps
  tccb_ctrl #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_data),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Cell store: one write port, one registered read port
  tccb_cell_mem #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output slot is free when empty or when its result transfers this cycle
  assign res_free = !out_valid_r || !out_stall;

  // Hold the result until taken; load a new one as the old one leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
